// ===== rtl/smx_pkg.sv =====
package smx_pkg;

  // Instruction kinds. The encoding follows the mode field of the input.
  typedef enum logic [4:0] {
    OP_BAD   = 5'd0,
    OP_PUSH  = 5'd1,
    OP_POP   = 5'd2,
    OP_LOAD  = 5'd3,
    OP_STORE = 5'd4,
    OP_VAR   = 5'd5,
    OP_PARAM = 5'd6,
    OP_PROC  = 5'd7,
    OP_DUP   = 5'd8,
    OP_ADD   = 5'd9,
    OP_MUL   = 5'd10,
    OP_INC   = 5'd11,
    OP_CMP   = 5'd12,
    OP_JMP   = 5'd13,
    OP_JLT   = 5'd14,
    OP_CALL  = 5'd15,
    OP_CALLV = 5'd16,
    OP_RETV  = 5'd17,
    OP_RET   = 5'd18
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_BADOP = 2'd2,
    ST_FAULT = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] opd;
  } item_t;

  typedef struct packed {
    logic [31:0] result_value;
    status_t     status;
    logic [15:0] next_pc;
    logic [7:0]  next_proc;
  } result_t;

  localparam int InDataW  = 40;
  localparam int OutDataW = 64;

endpackage

// ===== rtl/smx_front.sv =====
module smx_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           mode,
  input  logic [31:0]          operand,
  output logic                 q_valid,
  output smx_pkg::item_t       q_item,
  input  logic                 q_pop
);
  import smx_pkg::*;

  item_t       entry [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  item_t       dec;
  logic        push;

  // Unknown modes collapse to OP_BAD so the back end needs no range check.
  always_comb begin
    dec.opd = operand;
    unique case (mode)
      5'd1:    dec.op = OP_PUSH;
      5'd2:    dec.op = OP_POP;
      5'd3:    dec.op = OP_LOAD;
      5'd4:    dec.op = OP_STORE;
      5'd5:    dec.op = OP_VAR;
      5'd6:    dec.op = OP_PARAM;
      5'd7:    dec.op = OP_PROC;
      5'd8:    dec.op = OP_DUP;
      5'd9:    dec.op = OP_ADD;
      5'd10:   dec.op = OP_MUL;
      5'd11:   dec.op = OP_INC;
      5'd12:   dec.op = OP_CMP;
      5'd13:   dec.op = OP_JMP;
      5'd14:   dec.op = OP_JLT;
      5'd15:   dec.op = OP_CALL;
      5'd16:   dec.op = OP_CALLV;
      5'd17:   dec.op = OP_RETV;
      5'd18:   dec.op = OP_RET;
      default: dec.op = OP_BAD;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= dec;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/smx_back.sv =====
module smx_back #(
  parameter int STACK_DEPTH = 1024,
  parameter int CALL_DEPTH  = 64,
  parameter int NUM_PROCS   = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  smx_pkg::item_t       q_item,
  output logic                 q_pop,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smx_pkg::result_t     out_data
);
  import smx_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int FDW = $clog2(CALL_DEPTH + 1);
  localparam int FAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

  typedef struct packed {
    logic           wants;
    logic [SPW-1:0] base;
    logic [15:0]    pc;
    logic [7:0]     proc;
  } frame_t;

  typedef enum logic [2:0] {
    S_IDLE, S_R1, S_R2, S_MUL, S_RF, S_RV, S_OUT
  } state_t;

  logic [31:0] stack_mem [STACK_DEPTH];
  frame_t      frame_mem [CALL_DEPTH];

  state_t         state, state_next;
  logic [SPW-1:0] sp, sp_next;
  logic [SPW-1:0] fb, fb_next;
  logic [FDW-1:0] fd, fd_next;
  logic [7:0]     proc, proc_next;
  logic [15:0]    pc, pc_next;
  logic           at_start, at_start_next;
  logic [7:0]     main_proc, main_proc_next;
  op_t            op_r, op_r_next;
  logic [31:0]    opd_r, opd_r_next;
  logic [31:0]    tmp, tmp_next;
  logic           ovalid, ovalid_next;
  result_t        odata, odata_next;
  result_t        stash, stash_next;

  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [31:0]    mem_wdata;
  logic [31:0]    rdata;
  logic           fr_we;
  frame_t         fr_wdata;
  frame_t         fr_rdata;
  logic [FAW-1:0] fr_raddr;

  logic           fin;
  status_t        fin_st;
  logic [31:0]    fin_val;
  logic           tail_go;
  logic [31:0]    tail_v;

  assign out_valid = ovalid;
  assign out_data  = odata;

  always_comb begin
    op_t            op_c;
    logic [31:0]    opd_c;
    logic [SPW-1:0] sp_m1;
    logic [SPW-1:0] sp_m2;
    logic [15:0]    pc_inc;
    logic [SPW-1:0] spn;
    logic           wv;
    logic           wanted;
    result_t        o;

    op_c   = (state == S_IDLE) ? q_item.op : op_r;
    opd_c  = (state == S_IDLE) ? q_item.opd : opd_r;
    sp_m1  = sp - SPW'(1);
    sp_m2  = sp - SPW'(2);
    pc_inc = pc + 16'd1;
    wv     = (op_r == OP_RET);
    wanted = (fd == '0) ? 1'b1 : fr_rdata.wants;
    spn    = fb;
    o      = '0;

    state_next     = state;
    sp_next        = sp;
    fb_next        = fb;
    fd_next        = fd;
    proc_next      = proc;
    pc_next        = pc;
    at_start_next  = at_start;
    main_proc_next = main_proc;
    op_r_next      = op_r;
    opd_r_next     = opd_r;
    tmp_next       = tmp;
    ovalid_next    = ovalid && !out_ready;
    odata_next     = odata;
    stash_next     = stash;

    mem_we    = 1'b0;
    mem_addr  = sp_m1[AW-1:0];
    mem_wdata = 32'd0;
    fr_we     = 1'b0;
    fr_wdata  = '0;
    fr_raddr  = FAW'(fd - FDW'(1));
    q_pop     = 1'b0;
    fin       = 1'b0;
    fin_st    = ST_RUN;
    fin_val   = 32'd0;
    tail_go   = 1'b0;
    tail_v    = 32'd0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          op_r_next  = op_c;
          opd_r_next = opd_c;
          unique case (op_c)
            OP_PUSH, OP_PROC, OP_VAR, OP_PARAM: begin
              fin = 1'b1;
              if (sp == SPW'(STACK_DEPTH)) begin
                fin_st = ST_FAULT;
              end else begin
                mem_we   = 1'b1;
                mem_addr = sp[AW-1:0];
                if (op_c == OP_VAR) begin
                  mem_wdata = 32'(fb) + opd_c;
                end else if (op_c == OP_PARAM) begin
                  mem_wdata = 32'(fb) - opd_c - 32'd1;
                end else begin
                  mem_wdata = opd_c;
                end
                sp_next = sp + SPW'(1);
                pc_next = pc_inc;
              end
            end
            OP_POP: begin
              fin = 1'b1;
              if (sp == '0) begin
                fin_st = ST_FAULT;
              end else begin
                sp_next = sp_m1;
                pc_next = pc_inc;
              end
            end
            OP_JMP: begin
              fin     = 1'b1;
              pc_next = opd_c[15:0];
            end
            OP_LOAD, OP_INC, OP_JLT, OP_CALL, OP_CALLV, OP_DUP: begin
              if (sp == '0) begin
                fin    = 1'b1;
                fin_st = ST_FAULT;
              end else begin
                state_next = S_R1;
              end
            end
            OP_STORE, OP_ADD, OP_MUL, OP_CMP: begin
              if (sp < SPW'(2)) begin
                fin    = 1'b1;
                fin_st = ST_FAULT;
              end else begin
                state_next = S_R1;
              end
            end
            OP_RET, OP_RETV: begin
              state_next = S_RF;
            end
            default: begin
              fin    = 1'b1;
              fin_st = ST_BADOP;
            end
          endcase
        end
      end

      // rdata holds the top of stack.
      S_R1: begin
        unique case (op_r)
          OP_LOAD, OP_INC: begin
            if (rdata >= 32'(STACK_DEPTH)) begin
              fin    = 1'b1;
              fin_st = ST_FAULT;
            end else begin
              tmp_next   = rdata;
              mem_addr   = rdata[AW-1:0];
              state_next = S_R2;
            end
          end
          OP_JLT: begin
            fin     = 1'b1;
            sp_next = sp_m1;
            pc_next = rdata[31] ? opd_r[15:0] : pc_inc;
          end
          OP_DUP: begin
            fin = 1'b1;
            if (sp == SPW'(STACK_DEPTH)) begin
              fin_st = ST_FAULT;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = sp[AW-1:0];
              mem_wdata = rdata;
              sp_next   = sp + SPW'(1);
              pc_next   = pc_inc;
            end
          end
          OP_CALL, OP_CALLV: begin
            fin = 1'b1;
            if (rdata >= 32'(NUM_PROCS) || rdata > 32'd255) begin
              fin_st = ST_BADOP;
            end else if (fd == FDW'(CALL_DEPTH)) begin
              fin_st = ST_FAULT;
            end else begin
              fr_we          = 1'b1;
              fr_wdata.wants = (op_r == OP_CALL);
              fr_wdata.base  = fb;
              fr_wdata.pc    = pc_inc;
              fr_wdata.proc  = proc;
              fd_next        = fd + FDW'(1);
              sp_next        = sp_m1;
              fb_next        = sp_m1;
              proc_next      = rdata[7:0];
              pc_next        = 16'd0;
            end
          end
          default: begin
            // store, add, mul, cmp: fetch the second entry.
            tmp_next   = rdata;
            mem_addr   = sp_m2[AW-1:0];
            state_next = S_R2;
          end
        endcase
      end

      S_R2: begin
        unique case (op_r)
          OP_LOAD: begin
            fin       = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = sp_m1[AW-1:0];
            mem_wdata = rdata;
            pc_next   = pc_inc;
          end
          OP_INC: begin
            fin       = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = tmp[AW-1:0];
            mem_wdata = rdata + 32'd1;
            sp_next   = sp_m1;
            pc_next   = pc_inc;
          end
          OP_STORE: begin
            fin = 1'b1;
            if (tmp >= 32'(STACK_DEPTH)) begin
              fin_st = ST_FAULT;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = tmp[AW-1:0];
              mem_wdata = rdata;
              sp_next   = sp_m2;
              pc_next   = pc_inc;
            end
          end
          OP_MUL: begin
            tmp_next   = rdata * tmp;
            state_next = S_MUL;
          end
          default: begin
            fin       = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = sp_m2[AW-1:0];
            mem_wdata = (op_r == OP_ADD) ? rdata + tmp : rdata - tmp;
            sp_next   = sp_m1;
            pc_next   = pc_inc;
          end
        endcase
      end

      S_MUL: begin
        fin       = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = sp_m2[AW-1:0];
        mem_wdata = tmp;
        sp_next   = sp_m1;
        pc_next   = pc_inc;
      end

      // fr_rdata holds the innermost frame.
      S_RF: begin
        if (wanted != wv) begin
          fin    = 1'b1;
          fin_st = ST_BADOP;
        end else if (wv) begin
          if (sp == '0) begin
            fin    = 1'b1;
            fin_st = ST_FAULT;
          end else begin
            state_next = S_RV;
          end
        end else begin
          tail_go = 1'b1;
        end
      end

      S_RV: begin
        tail_go = 1'b1;
        tail_v  = rdata;
      end

      S_OUT: begin
        if (!ovalid || out_ready) begin
          ovalid_next = 1'b1;
          odata_next  = stash;
          state_next  = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Common tail of both return kinds.
    if (tail_go) begin
      fin = 1'b1;
      if (!opd_r[31] && opd_r > 32'(fb)) begin
        fin_st = ST_FAULT;
      end else begin
        if (!opd_r[31]) begin
          spn = fb - opd_r[SPW-1:0];
        end
        if (fd == '0) begin
          fin_st  = ST_DONE;
          fin_val = tail_v;
        end else begin
          fd_next   = fd - FDW'(1);
          proc_next = fr_rdata.proc;
          pc_next   = fr_rdata.pc;
          fb_next   = fr_rdata.base;
          sp_next   = spn;
          if (wv) begin
            if (spn == SPW'(STACK_DEPTH)) begin
              fin_st = ST_FAULT;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = spn[AW-1:0];
              mem_wdata = tail_v;
              sp_next   = spn + SPW'(1);
            end
          end
        end
      end
    end

    if (fin) begin
      if (fin_st != ST_RUN) begin
        sp_next       = '0;
        fb_next       = '0;
        fd_next       = '0;
        proc_next     = main_proc;
        pc_next       = 16'd0;
        at_start_next = 1'b1;
        mem_we        = 1'b0;
        fr_we         = 1'b0;
      end else begin
        at_start_next = 1'b0;
      end
      o.result_value = fin_val;
      o.status       = fin_st;
      o.next_pc      = pc_next;
      o.next_proc    = proc_next;
      if (!ovalid || out_ready) begin
        ovalid_next = 1'b1;
        odata_next  = o;
        state_next  = S_IDLE;
      end else begin
        stash_next = o;
        state_next = S_OUT;
      end
    end

    if (cfg_we) begin
      main_proc_next = cfg_data;
      if (at_start) begin
        proc_next = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_addr] <= mem_wdata;
    end else begin
      rdata <= stack_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      frame_mem[FAW'(fd)] <= fr_wdata;
    end
    fr_rdata <= frame_mem[fr_raddr];
  end

  always_ff @(posedge clk) begin
    op_r  <= op_r_next;
    opd_r <= opd_r_next;
    tmp   <= tmp_next;
    odata <= odata_next;
    stash <= stash_next;
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      fb        <= '0;
      fd        <= '0;
      proc      <= 8'd0;
      pc        <= 16'd0;
      at_start  <= 1'b1;
      main_proc <= 8'd0;
      ovalid    <= 1'b0;
    end else begin
      state     <= state_next;
      sp        <= sp_next;
      fb        <= fb_next;
      fd        <= fd_next;
      proc      <= proc_next;
      pc        <= pc_next;
      at_start  <= at_start_next;
      main_proc <= main_proc_next;
      ovalid    <= ovalid_next;
    end
  end

endmodule

// ===== rtl/stack_machine_execute_unit.sv =====
// Stack machine execute unit. Each input transaction carries one fetched
// instruction (mode and operand); for each one the unit returns exactly one
// output transaction with the procedure and pc of the next fetch, a status
// (running, finished, invalid instruction, stack or frame fault) and, when the
// main procedure returns, its value. Any status other than running ends the
// run: the unit clears its stack and frame state and points the next fetch at
// pc 0 of the procedure held in the configuration register, which may only be
// written while no instruction is in flight. Instructions pass through a
// two-entry queue in front of the executor, so the input keeps accepting while
// a result waits at the output, until both entries fill. Instructions run on
// the single-port value stack memory with a registered read: push, proc, var,
// param, pop and jmp need no read; dup, jlt and call read the top entry; ret
// and retv read the frame, ret also the top entry; load, inc, store, add and
// cmp read two values, and mul also registers the product before write-back.
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH = 1024,
  parameter int CALL_DEPTH  = 64,
  parameter int NUM_PROCS   = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0: mode[4:0], operand[36:5], zero fill.
  input  logic [smx_pkg::InDataW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0: next_proc[7:0], next_pc[23:8], status[25:24],
  // result_value[57:26], zero fill.
  output logic [smx_pkg::OutDataW-1:0]  m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [7:0]                    cfg_data
);
  import smx_pkg::*;

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  // The register must be written only while idle, which binds the user; the
  // block does not enforce it, so it can always take a transaction.
  assign cfg_ready = 1'b1;

  smx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .mode     (s_tdata[4:0]),
    .operand  (s_tdata[36:5]),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  smx_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .CALL_DEPTH  (CALL_DEPTH),
    .NUM_PROCS   (NUM_PROCS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {(OutDataW - $bits(result_t))'(0), res};

endmodule

// ===== rtl/smx_checker.sv =====
module smx_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);
  import smx_pkg::*;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A run that ends restarts at pc 0.
  a_restart_pc: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25:24] != ST_RUN |-> m_tdata[23:8] == 16'd0)
    else $error("ended run does not restart at pc 0");

  // Only a finished run carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25:24] != ST_DONE |-> m_tdata[57:26] == 32'd0)
    else $error("value given without finish");

  // After reset the queue is empty and nothing is offered.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("unit not clean after reset");

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
